### sv/gsvu_pkg.sv
// Package for the Gray-Scott voxel update core.
// Field widths, register indexes and register reset values.
// No dependencies.
package gsvu_pkg;

	localparam int unsigned CONC_W  = 16;  // Q1.15 concentration
	localparam int unsigned COEF_W  = 16;  // Q4.12 coefficient
	localparam int unsigned LANES_W = 64;  // four concentration lanes
	localparam int unsigned LANES   = 4;
	localparam int unsigned LAP_W   = 20;  // twelve lanes summed
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CONC_W-1:0] ONE_Q15 = 16'h8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FEED = 2'd0,
		CFG_KILL = 2'd1,
		CFG_STEP = 2'd2,
		CFG_DIFF = 2'd3
	} cfg_idx_t;

	localparam logic signed [COEF_W-1:0] FEED_RST = 16'sd287;
	localparam logic signed [COEF_W-1:0] KILL_RST = 16'sd287;
	localparam logic signed [COEF_W-1:0] STEP_RST = 16'sd4096;
	localparam logic signed [COEF_W-1:0] DIFF_RST = 16'sd1024;

endpackage

### sv/gsvu_if.sv
// Channel interfaces for the Gray-Scott voxel update core:
// voxel input, voxel result and register write.
// Depends on gsvu_pkg.
interface gsvu_in_if import gsvu_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CONC_W-1:0]   centre_u;
	logic [CONC_W-1:0]   centre_v;
	logic [LANES_W-1:0]  neighbour_u_first;
	logic [LANES_W-1:0]  neighbour_u_middle;
	logic [LANES_W-1:0]  neighbour_u_last;
	logic [LANES_W-1:0]  neighbour_v_first;
	logic [LANES_W-1:0]  neighbour_v_middle;
	logic [LANES_W-1:0]  neighbour_v_last;

	modport source (output valid, centre_u, centre_v, neighbour_u_first, neighbour_u_middle,
		neighbour_u_last, neighbour_v_first, neighbour_v_middle, neighbour_v_last,
		input ready);
	modport sink (input valid, centre_u, centre_v, neighbour_u_first, neighbour_u_middle,
		neighbour_u_last, neighbour_v_first, neighbour_v_middle, neighbour_v_last,
		output ready);
endinterface

interface gsvu_out_if import gsvu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CONC_W-1:0] next_u;
	logic [CONC_W-1:0] next_v;

	modport source (output valid, next_u, next_v, input ready);
	modport sink (input valid, next_u, next_v, output ready);
endinterface

interface gsvu_cfg_if import gsvu_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [COEF_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/gray_scott_voxel_update_core.sv
// Gray-Scott reaction-diffusion step for one voxel, five register stages.
// Depends on gsvu_pkg and the channel interfaces in gsvu_if.
//
//   channel    dir  payload                                  transfer
//   voxel_in   in   centre u/v, 12 neighbour u/v lanes       valid & ready
//   voxel_out  out  next_u, next_v                           valid & ready
//   cfg        in   index (0 feed,1 kill,2 step,3 diff), data  valid & ready
//
// One voxel per cycle while voxel_out is not stalled.
// Stages: Laplacians and u*v / u*v*v and rate products / derivative sums /
// step products / truncate, add and clamp into the output register.
// Stalls back-propagate stage by stage; bubbles are squeezed out.
// Reset clears the stage valid bits and loads the register defaults.
module gray_scott_voxel_update_core
	import gsvu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	gsvu_in_if.sink     voxel_in,
	gsvu_out_if.source  voxel_out,
	gsvu_cfg_if.sink    cfg
);

	localparam int unsigned DL_W  = COEF_W + LAP_W + 1;   // D * lap
	localparam int unsigned FU_W  = COEF_W + CONC_W + 1;  // F * (1 - u)
	localparam int unsigned FKV_W = COEF_W + CONC_W + 2;  // (F + K) * v
	localparam int unsigned UVV_W = 3*CONC_W - 30;
	localparam int unsigned D_W   = DL_W + 2;             // derivative, Q.27
	localparam int unsigned P_W   = COEF_W + D_W;         // step * derivative
	localparam int unsigned Q_W   = P_W - 24;
	localparam int unsigned R_W   = Q_W + 2;

	logic signed [COEF_W-1:0] feed_q, kill_q, step_q, diff_q;

	logic v_s1, v_s2, v_s3, v_s4, out_v_q;
	logic en1, en2, en3, en4, en_o;

	// ---- configuration ----
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_q <= FEED_RST;
			kill_q <= KILL_RST;
			step_q <= STEP_RST;
			diff_q <= DIFF_RST;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_FEED: feed_q <= $signed(cfg.data);
				CFG_KILL: kill_q <= $signed(cfg.data);
				CFG_STEP: step_q <= $signed(cfg.data);
				CFG_DIFF: diff_q <= $signed(cfg.data);
				default: ;
			endcase
		end
	end

	// ---- flow control ----
	assign en_o = !out_v_q || voxel_out.ready;
	assign en4  = !v_s4 || en_o;
	assign en3  = !v_s3 || en4;
	assign en2  = !v_s2 || en3;
	assign en1  = !v_s1 || en2;
	assign voxel_in.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1)  v_s1    <= voxel_in.valid;
			if (en2)  v_s2    <= v_s1;
			if (en3)  v_s3    <= v_s2;
			if (en4)  v_s4    <= v_s3;
			if (en_o) out_v_q <= v_s4;
		end
	end

	// ---- stage 1: Laplacians, u*v ----
	function automatic logic [LAP_W-1:0] lap_calc(
		input logic [CONC_W-1:0]  c,
		input logic [LANES_W-1:0] a,
		input logic [LANES_W-1:0] b,
		input logic [LANES_W-1:0] d
	);
		logic [LAP_W-1:0] sum;
		logic [LAP_W-1:0] c12;
		logic [LAP_W:0]   diff;
		sum = '0;
		for (int k = 0; k < LANES; k++) begin
			sum = sum + LAP_W'(a[k*CONC_W +: CONC_W]) + LAP_W'(b[k*CONC_W +: CONC_W])
				+ LAP_W'(d[k*CONC_W +: CONC_W]);
		end
		c12  = LAP_W'({c, 3'b000}) + LAP_W'({c, 2'b00});
		diff = {1'b0, sum} - {1'b0, c12};
		return diff[LAP_W] ? '0 : diff[LAP_W-1:0];
	endfunction

	logic [CONC_W-1:0]   u_s1, cv_s1;
	logic [LAP_W-1:0]    lapu_s1, lapv_s1;
	logic [2*CONC_W-1:0] uv_s1;

	always_ff @(posedge clk) begin
		if (en1 && voxel_in.valid) begin
			u_s1    <= voxel_in.centre_u;
			cv_s1   <= voxel_in.centre_v;
			lapu_s1 <= lap_calc(voxel_in.centre_u, voxel_in.neighbour_u_first,
				voxel_in.neighbour_u_middle, voxel_in.neighbour_u_last);
			lapv_s1 <= lap_calc(voxel_in.centre_v, voxel_in.neighbour_v_first,
				voxel_in.neighbour_v_middle, voxel_in.neighbour_v_last);
			uv_s1   <= voxel_in.centre_u * voxel_in.centre_v;
		end
	end

	// ---- stage 2: products ----
	logic [3*CONC_W-1:0]      uvv_full;
	logic signed [CONC_W:0]   one_minus_u;
	logic signed [COEF_W:0]   fk_sum;

	logic [CONC_W-1:0]        u_s2, cv_s2;
	logic [UVV_W-1:0]         uvv_s2;
	logic signed [DL_W-1:0]   dlu_s2, dlv_s2;
	logic signed [FU_W-1:0]   fu_s2;
	logic signed [FKV_W-1:0]  fkv_s2;

	assign uvv_full    = uv_s1 * cv_s1;
	assign one_minus_u = $signed({1'b0, ONE_Q15}) - $signed({1'b0, u_s1});
	assign fk_sum      = $signed({feed_q[COEF_W-1], feed_q})
		+ $signed({kill_q[COEF_W-1], kill_q});

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			u_s2   <= u_s1;
			cv_s2  <= cv_s1;
			uvv_s2 <= uvv_full[3*CONC_W-1:30];
			dlu_s2 <= diff_q * $signed({1'b0, lapu_s1});
			dlv_s2 <= diff_q * $signed({1'b0, lapv_s1});
			fu_s2  <= feed_q * one_minus_u;
			fkv_s2 <= fk_sum * $signed({1'b0, cv_s1});
		end
	end

	// ---- stage 3: derivatives ----
	logic signed [D_W-1:0] uvv_sh;
	logic [CONC_W-1:0]     u_s3, cv_s3;
	logic signed [D_W-1:0] du_s3, dv_s3;

	assign uvv_sh = $signed({{(D_W-UVV_W-12){1'b0}}, uvv_s2, 12'b0});

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			u_s3  <= u_s2;
			cv_s3 <= cv_s2;
			du_s3 <= D_W'(dlu_s2) - uvv_sh + D_W'(fu_s2);
			dv_s3 <= D_W'(dlv_s2) + uvv_sh - D_W'(fkv_s2);
		end
	end

	// ---- stage 4: step products ----
	logic [CONC_W-1:0]     u_s4, cv_s4;
	logic signed [P_W-1:0] pu_s4, pv_s4;

	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			u_s4  <= u_s3;
			cv_s4 <= cv_s3;
			pu_s4 <= step_q * du_s3;
			pv_s4 <= step_q * dv_s3;
		end
	end

	// ---- stage 5: truncate toward zero, add, clamp ----
	function automatic logic [CONC_W-1:0] advance(
		input logic [CONC_W-1:0]  c,
		input logic signed [P_W-1:0] p
	);
		logic [P_W-1:0]        mag;
		logic [Q_W-1:0]        qm;
		logic signed [R_W-1:0] r;
		mag = p[P_W-1] ? P_W'(-p) : P_W'(p);
		qm  = mag[P_W-1:24];
		if (p[P_W-1])
			r = $signed({{(R_W-CONC_W){1'b0}}, c}) - $signed({2'b00, qm});
		else
			r = $signed({{(R_W-CONC_W){1'b0}}, c}) + $signed({2'b00, qm});
		if (r[R_W-1])
			return '0;
		else if (r > $signed({{(R_W-CONC_W){1'b0}}, ONE_Q15}))
			return ONE_Q15;
		else
			return r[CONC_W-1:0];
	endfunction

	logic [CONC_W-1:0] next_u_q, next_v_q;

	always_ff @(posedge clk) begin
		if (en_o && v_s4) begin
			next_u_q <= advance(u_s4, pu_s4);
			next_v_q <= advance(cv_s4, pv_s4);
		end
	end

	assign voxel_out.valid  = out_v_q;
	assign voxel_out.next_u = next_u_q;
	assign voxel_out.next_v = next_v_q;

endmodule
